// ----- src/ansi_text_terminal_engine_assert.svh -----
// ----------------------------------------------------------------------------
// ANSI text terminal engine - assertion macros
// Concurrent assertion wrappers; they expand to nothing in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef ANSI_TEXT_TERMINAL_ENGINE_ASSERT_SVH
`define ANSI_TEXT_TERMINAL_ENGINE_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ATTE_ASSERT_SAME(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("assertion failed");

// next-cycle implication
`define ATTE_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("assertion failed");

`else

`define ATTE_ASSERT_SAME(label, clk, rst_n, cond, expr)
`define ATTE_ASSERT_NEXT(label, clk, rst_n, cond, expr)

`endif

`endif

// ----- src/atte_pkg.sv -----
// ----------------------------------------------------------------------------
// ANSI text terminal engine - package
// Shared types, character codes and the SGR attribute update function.
// ----------------------------------------------------------------------------
`default_nettype none

package atte_pkg;

    localparam int COL_W  = 8;
    localparam int ROW_W  = 6;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;

    localparam logic [CHAR_W-1:0] CHAR_CR     = 8'h0D;
    localparam logic [CHAR_W-1:0] CHAR_LF     = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_ESC    = 8'd27;
    localparam logic [CHAR_W-1:0] CHAR_LBRACK = 8'h5B;
    localparam logic [CHAR_W-1:0] CHAR_M      = 8'h6D;
    localparam logic [CHAR_W-1:0] CHAR_SEMI   = 8'h3B;
    localparam logic [CHAR_W-1:0] CHAR_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE   = 8'h39;

    localparam logic [ATTR_W-1:0] ATTR_DEFAULT  = 8'h07;
    localparam logic [ATTR_W-1:0] MASK_FG_COLOR = 8'hF8;
    localparam logic [ATTR_W-1:0] MASK_FG       = 8'hF0;
    localparam logic [ATTR_W-1:0] MASK_BG       = 8'h8F;
    localparam logic [ATTR_W-1:0] BIT_BRIGHT    = 8'h08;
    localparam logic [ATTR_W-1:0] BIT_BLINK     = 8'h80;
    localparam logic [ATTR_W-1:0] CLR_BRIGHT    = 8'hF7;
    localparam logic [ATTR_W-1:0] CLR_BLINK     = 8'h7F;
    localparam logic [ATTR_W-1:0] FG_WHITE_HI   = 8'h0F;
    localparam logic [ATTR_W-1:0] FG_WHITE      = 8'h07;

    localparam logic [7:0] SGR_RESET       = 8'd0;
    localparam logic [7:0] SGR_BRIGHT      = 8'd4;
    localparam logic [7:0] SGR_BLINK       = 8'd5;
    localparam logic [7:0] SGR_NO_BRIGHT   = 8'd24;
    localparam logic [7:0] SGR_NO_BLINK    = 8'd25;
    localparam logic [7:0] SGR_FG_FIRST    = 8'd30;
    localparam logic [7:0] SGR_FG_LAST     = 8'd37;
    localparam logic [7:0] SGR_FG_HI       = 8'd38;
    localparam logic [7:0] SGR_FG_DEFAULT  = 8'd39;
    localparam logic [7:0] SGR_BG_FIRST    = 8'd40;
    localparam logic [7:0] SGR_BG_LAST     = 8'd47;
    localparam logic [7:0] SGR_BG_DEFAULT  = 8'd49;

    localparam logic [COL_W-1:0] COLUMNS_RESET = 8'd80;
    localparam logic [ROW_W-1:0] ROWS_RESET    = 6'd25;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_ESC    = 2'd1,
        MODE_CSI    = 2'd2
    } mode_t;

    typedef struct packed {
        logic [COL_W-1:0] columns;
        logic [ROW_W-1:0] rows;
        logic             columns_wr;
        logic             rows_wr;
        logic [COL_W-1:0] columns_wdata;
        logic [ROW_W-1:0] rows_wdata;
    } cfg_t;

    typedef struct packed {
        logic              write_cell;
        logic [ROW_W-1:0]  cell_row;
        logic [COL_W-1:0]  cell_column;
        logic [CHAR_W-1:0] glyph;
        logic [ATTR_W-1:0] cell_attribute;
        logic              scroll_up;
        logic [ROW_W-1:0]  cursor_row_out;
        logic [COL_W-1:0]  cursor_column_out;
    } result_t;

    function automatic logic [2:0] ansi_to_vga(input logic [2:0] n);
        logic [2:0] v;
        unique case (n)
            3'd0:    v = 3'd0;
            3'd1:    v = 3'd4;
            3'd2:    v = 3'd2;
            3'd3:    v = 3'd6;
            3'd4:    v = 3'd1;
            3'd5:    v = 3'd5;
            3'd6:    v = 3'd3;
            default: v = 3'd7;
        endcase
        return v;
    endfunction

    function automatic logic [ATTR_W-1:0] apply_sgr(input logic [ATTR_W-1:0] a,
                                                    input logic [7:0] code);
        logic [7:0]        fg_idx;
        logic [7:0]        bg_idx;
        logic [ATTR_W-1:0] r;
        fg_idx = code - SGR_FG_FIRST;
        bg_idx = code - SGR_BG_FIRST;
        priority if (code == SGR_RESET)
            r = ATTR_DEFAULT;
        else if (code == SGR_BRIGHT)
            r = a | BIT_BRIGHT;
        else if (code == SGR_BLINK)
            r = a | BIT_BLINK;
        else if (code == SGR_NO_BRIGHT)
            r = a & CLR_BRIGHT;
        else if (code == SGR_NO_BLINK)
            r = a & CLR_BLINK;
        else if (code >= SGR_FG_FIRST && code <= SGR_FG_LAST)
            r = (a & MASK_FG_COLOR) | {5'd0, ansi_to_vga(fg_idx[2:0])};
        else if (code == SGR_FG_HI)
            r = (a & MASK_FG) | FG_WHITE_HI;
        else if (code == SGR_FG_DEFAULT)
            r = (a & MASK_FG) | FG_WHITE;
        else if (code == SGR_BG_FIRST || code == SGR_BG_DEFAULT)
            r = a & MASK_BG;
        else if (code > SGR_BG_FIRST && code <= SGR_BG_LAST)
            r = (a & MASK_BG) | {1'b0, ansi_to_vga(bg_idx[2:0]), 4'd0};
        else
            r = a;
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- src/atte_cfg.sv -----
// ----------------------------------------------------------------------------
// ANSI text terminal engine - configuration registers
// APB register file holding the screen size; a zero size reads back as one.
// ----------------------------------------------------------------------------
`default_nettype none

module atte_cfg (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [2:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic      [31:0]          prdata,
    output logic                      pready,
    output atte_pkg::cfg_t            cfg
);

    logic [atte_pkg::COL_W-1:0] columns_reg;
    logic [atte_pkg::COL_W-1:0] columns_next;
    logic [atte_pkg::ROW_W-1:0] rows_reg;
    logic [atte_pkg::ROW_W-1:0] rows_next;
    logic                       wr_en;
    logic [atte_pkg::COL_W-1:0] columns_wdata;
    logic [atte_pkg::ROW_W-1:0] rows_wdata;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb
    begin
        columns_wdata = pwdata[atte_pkg::COL_W-1:0];
        if (columns_wdata == '0)
            columns_wdata = atte_pkg::COL_W'(1);
        rows_wdata = pwdata[atte_pkg::ROW_W-1:0];
        if (rows_wdata == '0)
            rows_wdata = atte_pkg::ROW_W'(1);
    end

    always_comb
    begin
        columns_next = columns_reg;
        rows_next    = rows_reg;
        if (wr_en && !paddr[2])
            columns_next = columns_wdata;
        if (wr_en && paddr[2])
            rows_next = rows_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_reg <= atte_pkg::COLUMNS_RESET;
            rows_reg    <= atte_pkg::ROWS_RESET;
        end
        else
        begin
            columns_reg <= columns_next;
            rows_reg    <= rows_next;
        end
    end

    assign prdata = paddr[2] ? {{(32-atte_pkg::ROW_W){1'b0}}, rows_reg}
                             : {{(32-atte_pkg::COL_W){1'b0}}, columns_reg};

    always_comb
    begin
        cfg.columns       = columns_reg;
        cfg.rows          = rows_reg;
        cfg.columns_wr    = wr_en && !paddr[2];
        cfg.rows_wr       = wr_en && paddr[2];
        cfg.columns_wdata = columns_wdata;
        cfg.rows_wdata    = rows_wdata;
    end

endmodule

`default_nettype wire

// ----- src/atte_core.sv -----
// ----------------------------------------------------------------------------
// ANSI text terminal engine - parser and cursor core
// Escape parser, attribute and cursor state, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module atte_core #(
    parameter int MAX_PARAMS = 16
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire atte_pkg::cfg_t              cfg,
    input  wire logic                        step,
    input  wire logic [atte_pkg::CHAR_W-1:0] char_in,
    output atte_pkg::result_t                res
);

    localparam int PCW = $clog2(MAX_PARAMS);
    localparam logic [PCW-1:0] COUNT_LAST = PCW'(MAX_PARAMS - 1);

    atte_pkg::mode_t             mode_reg, mode_next;
    logic [atte_pkg::ROW_W-1:0]  row_reg, row_next;
    logic [atte_pkg::COL_W-1:0]  col_reg, col_next;
    logic [atte_pkg::ATTR_W-1:0] cur_attr_reg, cur_attr_next;
    logic [atte_pkg::ATTR_W-1:0] pend_attr_reg, pend_attr_next;
    logic [7:0]                  param_reg, param_next;
    logic [PCW-1:0]              count_reg, count_next;
    atte_pkg::result_t           res_reg, res_next;

    logic        as_normal, csi_enter, csi_commit, csi_digit, csi_sep;
    logic        is_cr, is_lf, is_esc, is_print, is_digit;
    logic [atte_pkg::COL_W:0] col_inc;
    logic [atte_pkg::ROW_W:0] row_inc;
    logic        col_wrap, row_over, next_row, scroll;
    logic [11:0] param_acc;
    logic [atte_pkg::ATTR_W-1:0] sgr_attr;

    assign is_digit = (char_in >= atte_pkg::CHAR_ZERO) && (char_in <= atte_pkg::CHAR_NINE);
    assign is_cr    = char_in == atte_pkg::CHAR_CR;
    assign is_lf    = char_in == atte_pkg::CHAR_LF;
    assign is_esc   = char_in == atte_pkg::CHAR_ESC;

    always_comb
    begin
        as_normal  = 1'b0;
        csi_enter  = 1'b0;
        csi_commit = 1'b0;
        csi_digit  = 1'b0;
        csi_sep    = 1'b0;
        unique case (mode_reg)
            atte_pkg::MODE_ESC:
            begin
                if (char_in == atte_pkg::CHAR_LBRACK)
                    csi_enter = 1'b1;
                else
                    as_normal = 1'b1;
            end
            atte_pkg::MODE_CSI:
            begin
                priority if (char_in == atte_pkg::CHAR_M)
                    csi_commit = 1'b1;
                else if (is_digit)
                    csi_digit = 1'b1;
                else if (char_in == atte_pkg::CHAR_SEMI && count_reg < COUNT_LAST)
                    csi_sep = 1'b1;
                else
                    as_normal = 1'b1;
            end
            default:
                as_normal = 1'b1;
        endcase
    end

    // parse mode next state
    always_comb
    begin
        mode_next = mode_reg;
        if (step)
        begin
            priority if (csi_enter || csi_digit || csi_sep)
                mode_next = atte_pkg::MODE_CSI;
            else if (csi_commit)
                mode_next = atte_pkg::MODE_NORMAL;
            else if (is_esc)
                mode_next = atte_pkg::MODE_ESC;
            else
                mode_next = atte_pkg::MODE_NORMAL;
        end
    end

    assign is_print = as_normal && !is_cr && !is_lf && !is_esc;
    assign col_inc  = {1'b0, col_reg} + 1'b1;
    assign col_wrap = col_inc >= {1'b0, cfg.columns};
    assign next_row = as_normal && (is_lf || (is_print && col_wrap));
    assign row_inc  = {1'b0, row_reg} + 1'b1;
    assign row_over = row_inc >= {1'b0, cfg.rows};
    assign scroll   = next_row && row_over;

    assign param_acc = 12'(param_reg) * 12'd10 + 12'(char_in - atte_pkg::CHAR_ZERO);
    assign sgr_attr  = atte_pkg::apply_sgr(pend_attr_reg, param_reg);

    // cursor, attribute and parameter datapath
    always_comb
    begin
        row_next       = row_reg;
        col_next       = col_reg;
        cur_attr_next  = cur_attr_reg;
        pend_attr_next = pend_attr_reg;
        param_next     = param_reg;
        count_next     = count_reg;
        if (step)
        begin
            if (as_normal && (is_cr || is_lf))
                col_next = '0;
            else if (is_print)
                col_next = col_wrap ? '0 : col_inc[atte_pkg::COL_W-1:0];
            if (next_row)
                row_next = row_over ? cfg.rows - 1'b1 : row_inc[atte_pkg::ROW_W-1:0];
            if (csi_enter)
            begin
                pend_attr_next = cur_attr_reg;
                param_next     = '0;
                count_next     = '0;
            end
            if (csi_commit)
                cur_attr_next = sgr_attr;
            if (csi_digit)
                param_next = (param_acc > 12'd255) ? 8'hFF : param_acc[7:0];
            if (csi_sep)
            begin
                pend_attr_next = sgr_attr;
                param_next     = '0;
                count_next     = count_reg + 1'b1;
            end
        end
        else
        begin
            if (cfg.columns_wr && col_reg >= cfg.columns_wdata)
                col_next = cfg.columns_wdata - 1'b1;
            if (cfg.rows_wr && row_reg >= cfg.rows_wdata)
                row_next = cfg.rows_wdata - 1'b1;
        end
    end

    always_comb
    begin
        res_next = res_reg;
        if (step)
        begin
            res_next.write_cell        = is_print;
            res_next.cell_row          = is_print ? row_reg : '0;
            res_next.cell_column       = is_print ? col_reg : '0;
            res_next.glyph             = is_print ? char_in : '0;
            res_next.cell_attribute    = is_print ? cur_attr_reg : '0;
            res_next.scroll_up         = scroll;
            res_next.cursor_row_out    = row_next;
            res_next.cursor_column_out = col_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= atte_pkg::MODE_NORMAL;
            row_reg       <= '0;
            col_reg       <= '0;
            cur_attr_reg  <= atte_pkg::ATTR_DEFAULT;
            pend_attr_reg <= atte_pkg::ATTR_DEFAULT;
            param_reg     <= '0;
            count_reg     <= '0;
        end
        else
        begin
            mode_reg      <= mode_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            cur_attr_reg  <= cur_attr_next;
            pend_attr_reg <= pend_attr_next;
            param_reg     <= param_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res = res_reg;

endmodule

`default_nettype wire

// ----- src/ansi_text_terminal_engine.sv -----
// ----------------------------------------------------------------------------
// ANSI text terminal engine - top level
// Character stream in, cell writes out, APB access to the screen size.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one character byte per transaction on s_tdata[7:0].
//   Master stream: one result per character: the cell write flag on
//   m_tuser, cell position, glyph, attribute, scroll request and new cursor
//   position on m_tdata.
//   APB: screen_columns at 0x0, screen_rows at 0x4; write only while the
//   streams are idle. A write that shrinks the screen pulls the cursor in.
//   Pipeline: an accepted character is held in the input register, then the
//   parse stage loads the result register and m_tvalid rises. Throughput: one
//   character per cycle while m_tready is high, set by the single parse stage
//   that updates cursor and attribute state in the same cycle it reads them.
//   Receiver stall: the result register holds, the input register takes one
//   more character, then s_tready drops until m_tready returns.
//   Reset: cursor at 0,0, attribute 0x07, parser in normal mode, screen
//   80 x 25; both streams empty.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ansi_text_terminal_engine_assert.svh"

module ansi_text_terminal_engine #(
    parameter int MAX_PARAMS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // slave stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] char_in
    // master stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // [5:0] cell_row, [13:6] cell_column,
                                        // [21:14] glyph, [29:22] cell_attribute,
                                        // [30] scroll_up, [36:31] cursor_row_out,
                                        // [44:37] cursor_column_out, [47:45] zero
    output logic [0:0]       m_tuser,   // [0] write_cell
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    atte_pkg::cfg_t    cfg;
    atte_pkg::result_t res;

    logic                          in_valid_reg, in_valid_next;
    logic [atte_pkg::CHAR_W-1:0]   char_reg;
    logic                          out_valid_reg, out_valid_next;
    logic                          advance;
    logic                          step;
    logic                          s_fire;

    atte_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    atte_core #(
        .MAX_PARAMS (MAX_PARAMS)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .step    (step),
        .char_in (char_reg),
        .res     (res)
    );

    assign advance  = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_fire)
            in_valid_next = 1'b1;
        else if (step)
            in_valid_next = 1'b0;
        out_valid_next = out_valid_reg;
        if (step)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
            char_reg <= s_tdata;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = res.write_cell;
    assign m_tdata  = {3'b000, res.cursor_column_out, res.cursor_row_out, res.scroll_up,
                       res.cell_attribute, res.glyph, res.cell_column, res.cell_row};

    `ATTE_ASSERT_NEXT(a_in_captured, clk, rst_n, s_fire, in_valid_reg)
    `ATTE_ASSERT_NEXT(a_step_gives_result, clk, rst_n, step, out_valid_reg)
    `ATTE_ASSERT_NEXT(a_in_held_on_stall, clk, rst_n, in_valid_reg && !advance, in_valid_reg)
    `ATTE_ASSERT_SAME(a_no_write_zero, clk, rst_n, out_valid_reg && !res.write_cell, m_tdata[29:0] == 30'd0)

endmodule

`default_nettype wire
